@@ rtl/pia_pkg.sv @@
// Shared widths and operation codes for the packed instruction ALU evaluator.
package pia_pkg;

    localparam int DATA_W = 32;
    localparam int WORD_W = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'b00,
        OP_SUB = 2'b01,
        OP_MUL = 2'b10,
        OP_DIV = 2'b11
    } t_op;

    typedef enum logic {
        FUNC_INSTR = 1'b0,
        FUNC_WORD  = 1'b1
    } t_func;

endpackage

@@ rtl/pia_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
interface pia_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [pia_pkg::DATA_W-1:0] data;

    modport source (output valid, output func, output data, input ready);
    modport sink   (input valid, input func, input data, output ready);
endinterface

interface pia_out_if;
    logic                       valid;
    logic                       ready;
    logic [pia_pkg::DATA_W-1:0] result;
    logic                       divide_by_zero;

    modport source (output valid, output result, output divide_by_zero, input ready);
    modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

@@ rtl/packed_instruction_alu_evaluator.sv @@
// Packed instruction ALU evaluator: unpacks operands and folds them through one shared ALU.
//
// Input channel i_in carries transactions of two kinds. func 0 loads an instruction word:
// operation count, two-bit opcodes and operand width; it abandons any evaluation in progress.
// func 1 carries one 16-bit operand word (low half of data); it is dropped when no
// instruction is pending. Operands are unpacked MSB-first and applied strictly left to right
// with 32-bit wrapping add, subtract, multiply and divide. Division by zero gives all ones
// and sets divide_by_zero.
// Output channel o_out carries one transaction after the word that completes the last
// operand. Padding bits of that word are dropped.
// Sequencing: an instruction word is taken in the idle state. Each operand that an operand
// word completes passes through the extract and apply steps; a division with a nonzero
// divisor then runs one quotient bit per cycle through the divide subtractor. The last
// operand leads to the finish step. i_in.ready is high only between these sequences.
// The result sits in an output register; if the receiver stalls while an earlier result
// is still held, the finish step waits until that register is free.
// Reset clears the sequencer, the pending instruction and the output valid.
module packed_instruction_alu_evaluator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pia_in_if.sink          i_in,
    pia_out_if.source       o_out
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_EXTRACT = 5'b00010,
        S_APPLY   = 5'b00100,
        S_DIV     = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state       r_state;
    logic [15:0]  r_ops;
    logic [3:0]   r_cnt;
    logic [4:0]   r_width;
    logic [31:0]  r_buf;
    logic [5:0]   r_fill;
    logic [3:0]   r_done;
    logic [31:0]  r_acc;
    logic         r_err;
    logic         r_busy;
    logic [15:0]  r_opnd;
    logic [15:0]  r_rem;
    logic [4:0]   r_step;
    logic [31:0]  r_res;
    logic         r_dz;
    logic         r_out_vld;

    logic         w_in_acc;
    logic [4:0]   w_wsh;
    logic [31:0]  w_wraw;
    logic [5:0]   w_shift;
    logic [31:0]  w_mask;
    logic [31:0]  w_val;
    logic         w_have;
    logic         w_last;
    logic [2:0]   w_k;
    logic [3:0]   w_base;
    logic [1:0]   w_code;
    logic [47:0]  w_prod;
    logic [16:0]  w_dsh;
    logic [16:0]  w_ddiff;
    logic         w_ge;
    logic         w_out_free;
    logic         w_finish;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign w_wsh  = 5'd23 - {1'b0, i_in.data[31:29], 1'b0};
    assign w_wraw = i_in.data >> w_wsh;

    assign w_shift = r_fill - {1'b0, r_width};
    assign w_mask  = (32'h1 << r_width) - 32'h1;
    assign w_val   = (r_buf >> w_shift) & w_mask;
    assign w_have  = (r_fill >= {1'b0, r_width});
    assign w_last  = (r_done == r_cnt + 4'd1);

    assign w_k    = 3'(r_done - 4'd1);
    assign w_base = 4'd15 - {w_k, 1'b0};
    assign w_code = r_ops[w_base -: 2];

    assign w_prod  = 48'(r_acc) * 48'(r_opnd);
    assign w_dsh   = {r_rem, r_acc[31]};
    assign w_ge    = (w_dsh >= {1'b0, r_opnd});
    assign w_ddiff = w_dsh - {1'b0, r_opnd};

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_width   <= '0;
            r_fill    <= '0;
            r_done    <= '0;
            r_err     <= 1'b0;
            r_busy    <= 1'b0;
            r_ops     <= '0;
            r_buf     <= '0;
            r_acc     <= '0;
            r_step    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (pia_pkg::t_func'(i_in.func) == pia_pkg::FUNC_INSTR) begin
                            r_cnt   <= {1'b0, i_in.data[31:29]} + 4'd1;
                            r_ops   <= i_in.data[28:13];
                            r_width <= {1'b0, w_wraw[3:0]} + 5'd1;
                            r_buf   <= '0;
                            r_fill  <= '0;
                            r_done  <= '0;
                            r_acc   <= '0;
                            r_err   <= 1'b0;
                            r_busy  <= 1'b1;
                        end else if (r_busy) begin
                            r_buf   <= {r_buf[15:0], i_in.data[15:0]};
                            r_fill  <= r_fill + 6'd16;
                            r_state <= S_EXTRACT;
                        end
                    end
                end
                S_EXTRACT: begin
                    if (w_last) begin
                        r_state <= S_DONE;
                    end else if (w_have) begin
                        r_opnd  <= w_val[15:0];
                        r_fill  <= w_shift;
                        r_state <= S_APPLY;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_APPLY: begin
                    if (r_done == 4'd0) begin
                        r_acc   <= {16'b0, r_opnd};
                        r_done  <= r_done + 4'd1;
                        r_state <= S_EXTRACT;
                    end else if (pia_pkg::t_op'(w_code) == pia_pkg::OP_DIV &&
                                 r_opnd != 16'd0) begin
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_done  <= r_done + 4'd1;
                        r_state <= S_EXTRACT;
                        case (pia_pkg::t_op'(w_code))
                            pia_pkg::OP_ADD: r_acc <= r_acc + {16'b0, r_opnd};
                            pia_pkg::OP_SUB: r_acc <= r_acc - {16'b0, r_opnd};
                            pia_pkg::OP_MUL: r_acc <= w_prod[31:0];
                            pia_pkg::OP_DIV: begin
                                r_acc <= '1;
                                r_err <= 1'b1;
                            end
                            default: r_acc <= r_acc;
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? w_ddiff[15:0] : w_dsh[15:0];
                    r_acc  <= {r_acc[30:0], w_ge};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_done  <= r_done + 4'd1;
                        r_state <= S_EXTRACT;
                    end
                end
                S_DONE: begin
                    if (w_finish) begin
                        r_busy    <= 1'b0;
                        r_buf     <= '0;
                        r_fill    <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_finish) begin
            r_res     <= r_acc;
            r_dz      <= r_err;
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.result         = r_res;
    assign o_out.divide_by_zero = r_dz;

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_cnt + 4'd1)
        else $error("operand count ran past the instruction");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < 6'd32)
        else $error("bit buffer overfilled");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_opnd != 16'd0))
        else $error("divide sequence started with zero divisor");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result raised outside the finish step");

endmodule

@@ dv/pia_eval_checker.sv @@
// Checker: predicts each evaluation from the accepted input transactions and compares results.
module pia_eval_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pia_in_if    i_in_ch,
    pia_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pia_pkg::DATA_W-1:0] value;
        logic                       dbz;
    } t_outcome;

    logic [15:0]                op_list;
    logic [3:0]                 op_count;
    logic [4:0]                 opnd_width;
    logic [31:0]                bit_buf;
    logic [5:0]                 bit_fill;
    logic [3:0]                 opnds_done;
    logic [pia_pkg::DATA_W-1:0] acc;
    logic                       div_zero_seen;
    logic                       loading;

    t_outcome expected_results[$];
    t_outcome head;
    int       fails;

    task automatic fold_operand(input logic [pia_pkg::DATA_W-1:0] operand);
        int           slot;
        pia_pkg::t_op code;
        if (opnds_done == 4'd0) begin
            acc = operand;
        end else begin
            slot = (int'(opnds_done) - 1) & 7;
            code = pia_pkg::t_op'(op_list[15 - 2 * slot -: 2]);
            case (code)
                pia_pkg::OP_ADD: acc = acc + operand;
                pia_pkg::OP_SUB: acc = acc - operand;
                pia_pkg::OP_MUL: acc = acc * operand;
                pia_pkg::OP_DIV: begin
                    if (operand == '0) begin
                        acc           = '1;
                        div_zero_seen = 1'b1;
                    end else begin
                        acc = acc / operand;
                    end
                end
                default: acc = acc;
            endcase
        end
    endtask

    task automatic predict_evaluation(input logic func_bit,
                                      input logic [pia_pkg::DATA_W-1:0] data);
        int                         width_lsb;
        int                         shift;
        logic [pia_pkg::DATA_W-1:0] operand;
        t_outcome                   outcome;
        if (pia_pkg::t_func'(func_bit) == pia_pkg::FUNC_INSTR) begin
            op_count      = {1'b0, data[31:29]} + 4'd1;
            op_list       = data[28:13];
            width_lsb     = 25 - 2 * int'(op_count);
            opnd_width    = {1'b0, data[width_lsb +: 4]} + 5'd1;
            bit_buf       = '0;
            bit_fill      = '0;
            opnds_done    = '0;
            acc           = '0;
            div_zero_seen = 1'b0;
            loading       = 1'b1;
        end else if (loading) begin
            bit_buf  = {bit_buf[15:0], data[pia_pkg::WORD_W-1:0]};
            bit_fill = bit_fill + 6'd16;
            while (bit_fill >= opnd_width && opnds_done <= op_count) begin
                shift    = int'(bit_fill) - int'(opnd_width);
                operand  = (bit_buf >> shift) & ((32'd1 << opnd_width) - 32'd1);
                bit_fill = shift[5:0];
                fold_operand(operand);
                opnds_done = opnds_done + 4'd1;
            end
            if (opnds_done > op_count) begin
                outcome.value = acc;
                outcome.dbz   = div_zero_seen;
                expected_results.push_back(outcome);
                loading  = 1'b0;
                bit_buf  = '0;
                bit_fill = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_list       = '0;
            op_count      = '0;
            opnd_width    = '0;
            bit_buf       = '0;
            bit_fill      = '0;
            opnds_done    = '0;
            acc           = '0;
            div_zero_seen = 1'b0;
            loading       = 1'b0;
            expected_results.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_evaluation(i_in_ch.func, i_in_ch.data);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction: result %h divide_by_zero %b",
                             $time, i_out_ch.result, i_out_ch.divide_by_zero);
                    fails++;
                end else begin
                    head = expected_results.pop_front();
                    if (i_out_ch.result !== head.value) begin
                        $display("%0t: result expected %h actual %h",
                                 $time, head.value, i_out_ch.result);
                        fails++;
                    end
                    if (i_out_ch.divide_by_zero !== head.dbz) begin
                        $display("%0t: divide_by_zero expected %b actual %b",
                                 $time, head.dbz, i_out_ch.divide_by_zero);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

@@ dv/testbench.sv @@
// Top level: clock, reset, instruction and operand stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_TX   = 2'd1,
        PH_RX   = 2'd2,
        PH_BOTH = 2'd3
    } t_phase;

    localparam int ITEM_TARGET    = 1650;
    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     pending;
    int     idle_cycles = 0;
    int     items_sent  = 0;
    logic   dut_loading = 1'b0;
    t_phase phase       = PH_NONE;
    t_phase rx_phase    = PH_NONE;

    int           prog_n;
    pia_pkg::t_op prog_ops [8];
    int           prog_w;
    logic [15:0]  prog_vals [9];

    pia_in_if  in_ch ();
    pia_out_if out_ch ();

    packed_instruction_alu_evaluator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pia_eval_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic send_item(input pia_pkg::t_func kind,
                             input logic [pia_pkg::DATA_W-1:0] word);
        while ((phase == PH_TX && $urandom_range(99) < 65) ||
               (phase == PH_BOTH && $urandom_range(99) < 14)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= kind;
        in_ch.data  <= word;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic send_program(input logic truncate);
        logic [31:0]  instr;
        logic [143:0] stream;
        logic [15:0]  upper;
        int           pos;
        int           nwords;
        instr        = $urandom;
        instr[31:29] = 3'(prog_n - 1);
        for (int i = 0; i < prog_n; i++) instr[28 - 2 * i -: 2] = prog_ops[i];
        instr[28 - 2 * prog_n -: 4] = 4'(prog_w - 1);
        for (int k = 0; k < 9; k++) stream[16 * k +: 16] = 16'($urandom_range(65535));
        pos = 0;
        for (int i = 0; i <= prog_n; i++) begin
            for (int b = prog_w - 1; b >= 0; b--) begin
                stream[143 - pos] = prog_vals[i][b];
                pos++;
            end
        end
        nwords = (pos + 15) / 16;
        if (truncate) nwords = $urandom_range(nwords - 1);
        send_item(pia_pkg::FUNC_INSTR, instr);
        for (int k = 0; k < nwords; k++) begin
            upper = 16'($urandom_range(65535));
            send_item(pia_pkg::FUNC_WORD, {upper, stream[143 - 16 * k -: 16]});
        end
        items_sent += 1 + nwords;
        dut_loading = truncate;
    endtask

    task automatic random_program();
        logic [31:0] top;
        logic [31:0] pick;
        prog_n = $urandom_range(1, 8);
        prog_w = $urandom_range(1, 16);
        top    = (32'd1 << prog_w) - 32'd1;
        for (int i = 0; i < 8; i++) prog_ops[i] = pia_pkg::t_op'($urandom_range(3));
        for (int i = 0; i < 9; i++) begin
            pick = $urandom_range(9);
            case (pick)
                0:       prog_vals[i] = 16'd0;
                1:       prog_vals[i] = top[15:0];
                2:       prog_vals[i] = 16'd1;
                default: begin
                    pick         = $urandom_range(top);
                    prog_vals[i] = pick[15:0];
                end
            endcase
        end
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= !((rx_phase == PH_RX && $urandom_range(99) < 65) ||
                              (rx_phase == PH_BOTH && $urandom_range(99) < 14));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int next_switch;
        int choice;
        in_ch.valid <= 1'b0;
        in_ch.func  <= pia_pkg::FUNC_INSTR;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prog_n = 1; prog_w = 16; prog_ops[0] = pia_pkg::OP_ADD;
        prog_vals[0] = 16'hFFFF; prog_vals[1] = 16'hFFFF;
        send_program(1'b0);

        prog_n = 1; prog_w = 4; prog_ops[0] = pia_pkg::OP_SUB;
        prog_vals[0] = 16'd0; prog_vals[1] = 16'd15;
        send_program(1'b0);

        prog_n = 3; prog_w = 16;
        for (int i = 0; i < 3; i++) prog_ops[i] = pia_pkg::OP_MUL;
        for (int i = 0; i < 4; i++) prog_vals[i] = 16'hFFFF;
        send_program(1'b0);

        prog_n = 8; prog_w = 1;
        for (int i = 0; i < 8; i++) prog_ops[i] = pia_pkg::OP_DIV;
        for (int i = 0; i < 9; i++) prog_vals[i] = 16'd1;
        prog_vals[2] = 16'd0;
        send_program(1'b0);

        prog_n = 4; prog_w = 5;
        prog_ops[0] = pia_pkg::OP_ADD; prog_ops[1] = pia_pkg::OP_SUB;
        prog_ops[2] = pia_pkg::OP_MUL; prog_ops[3] = pia_pkg::OP_DIV;
        prog_vals[0] = 16'd31; prog_vals[1] = 16'd7; prog_vals[2] = 16'd3;
        prog_vals[3] = 16'd9; prog_vals[4] = 16'd2;
        send_program(1'b0);

        send_item(pia_pkg::FUNC_WORD, 32'hFFFF_FFFF);
        items_sent += 1;

        prog_n = 2; prog_w = 16; prog_ops[0] = pia_pkg::OP_ADD; prog_ops[1] = pia_pkg::OP_MUL;
        prog_vals[0] = 16'h1234; prog_vals[1] = 16'h8000; prog_vals[2] = 16'h0003;
        send_program(1'b1);

        prog_n = 1; prog_w = 16; prog_ops[0] = pia_pkg::OP_DIV;
        prog_vals[0] = 16'hFFFF; prog_vals[1] = 16'h0007;
        send_program(1'b0);

        next_switch = items_sent;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= next_switch) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                phase = t_phase'((int'(phase) + 1) % 4);
                rx_phase <= phase;
                next_switch += PHASE_ITEMS;
            end
            choice = $urandom_range(99);
            if (choice < 85) begin
                random_program();
                send_program(1'b0);
            end else if (choice < 93) begin
                random_program();
                send_program(1'b1);
            end else if (!dut_loading) begin
                send_item(pia_pkg::FUNC_WORD, $urandom);
                items_sent += 1;
            end
        end

        in_ch.valid <= 1'b0;
        phase = PH_NONE;
        rx_phase <= PH_NONE;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pia_pkg.sv
rtl/pia_if.sv
rtl/packed_instruction_alu_evaluator.sv
dv/pia_eval_checker.sv
dv/testbench.sv
